// ----- hw/rtl/iqrtm_pkg.sv -----
// Shared constants and types for the IQR outlier trimmed mean block.
package iqrtm_pkg;

  localparam int MAX_SAMPLES_DEF = 64;
  localparam int SAMPLE_W        = 32;
  localparam int FACTOR_W        = 16;
  localparam int KEPT_W          = 7;
  localparam int PROD_W          = SAMPLE_W + FACTOR_W;
  localparam int WIDEN_W         = PROD_W - 8;
  localparam int HI_W            = WIDEN_W + 1;

  localparam logic [FACTOR_W-1:0] FACTOR_RST = 16'd384;

  // register index, decoded from paddr[2]
  localparam logic REG_FACTOR = 1'b0;

  // control broadcast to every cell
  typedef struct packed {
    logic shift;   // load chain shifts one sample in
    logic copy;    // own sample into the ring token, clear counters
    logic count;   // ring rotates, cells rank their own sample
    logic mark;    // quartile hit flags into the token
    logic rotate;  // ring rotates, nothing else
  } cell_ctl_t;

  // token circulating around the ring
  typedef struct packed {
    logic [SAMPLE_W-1:0] val;
    logic                vld;
    logic                hlo;
    logic                hhi;
  } tok_t;

endpackage

// ----- hw/rtl/iqrtm_cell.sv -----
// One cell of the sample chain: holds a sample, ranks it against the ring tokens.
module iqrtm_cell #(
  parameter int MAX_SAMPLES = iqrtm_pkg::MAX_SAMPLES_DEF,
  parameter int IDX         = 0,
  localparam int CW         = $clog2(MAX_SAMPLES + 1)
) (
  input  logic                              clk,
  input  iqrtm_pkg::cell_ctl_t              ctl,
  input  logic [CW-1:0]                     cnt,
  input  logic [CW-1:0]                     k_lo,
  input  logic [CW-1:0]                     k_hi,
  input  logic [iqrtm_pkg::SAMPLE_W-1:0]    val_in,
  input  iqrtm_pkg::tok_t                   tok_in,
  output logic [iqrtm_pkg::SAMPLE_W-1:0]    val_o,
  output iqrtm_pkg::tok_t                   tok_o
);

  localparam logic [CW-1:0] MY_IDX = CW'(IDX);

  logic [iqrtm_pkg::SAMPLE_W-1:0] val_r;
  iqrtm_pkg::tok_t                tok_r;
  logic [CW-1:0]                  below_r;
  logic [CW-1:0]                  le_r;
  logic                           own_vld;
  logic                           hit_lo;
  logic                           hit_hi;

  // newest sample sits in cell 0, so the first cnt cells hold the set
  assign own_vld = MY_IDX < cnt;
  assign hit_lo  = own_vld && (below_r < k_lo) && (k_lo <= le_r);
  assign hit_hi  = own_vld && (below_r < k_hi) && (k_hi <= le_r);

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      val_r <= val_in;
    end
    if (ctl.copy) begin
      tok_r   <= '{val: val_r, vld: own_vld, hlo: 1'b0, hhi: 1'b0};
      below_r <= '0;
      le_r    <= '0;
    end else if (ctl.count) begin
      tok_r <= tok_in;
      if (tok_r.vld && (tok_r.val < val_r)) begin
        below_r <= below_r + CW'(1);
      end
      if (tok_r.vld && (tok_r.val <= val_r)) begin
        le_r <= le_r + CW'(1);
      end
    end else if (ctl.mark) begin
      tok_r.hlo <= hit_lo;
      tok_r.hhi <= hit_hi;
    end else if (ctl.rotate) begin
      tok_r <= tok_in;
    end
  end

  assign val_o = val_r;
  assign tok_o = tok_r;

endmodule

// ----- hw/rtl/iqrtm_div.sv -----
// Restoring divider, one quotient bit per cycle.
module iqrtm_div #(
  parameter int NW = 39,
  parameter int DW = 7
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [NW-1:0] quot
);

  localparam int IW = $clog2(NW);

  logic          busy_r;
  logic          done_r;
  logic [IW-1:0] it_r;
  logic [NW-1:0] q_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] d_r;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;

  assign trial = {rem_r, q_r[NW-1]};
  assign ge    = trial >= {1'b0, d_r};
  assign diff  = trial - {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      it_r   <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        it_r   <= '0;
      end else if (busy_r) begin
        it_r <= it_r + IW'(1);
        if (it_r == IW'(NW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      q_r   <= dividend;
      rem_r <= '0;
      d_r   <= divisor;
    end else if (busy_r) begin
      q_r   <= {q_r[NW-2:0], ge};
      rem_r <= ge ? diff[DW-1:0] : trial[DW-1:0];
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

// ----- hw/rtl/iqr_outlier_trimmed_mean.sv -----
// Top level: IQR outlier trimmed mean over one set of latency samples.
//
//  channel  dir  handshake                 contents
//  in_      in   tvalid/tready             tdata = sample, tlast = end of set
//  out_     out  tvalid/tready             tdata = mean, kept_count; tuser = overflow
//  cfg_     in   APB psel/penable/pready   addr 0: outlier_factor (Q8.8)
//
// Samples load one word per cycle, while in_tready is high, into a chain of MAX_SAMPLES cells.
// After the last word a set runs the ring passes (rank count, quartile drain,
// bound sum), then the bit-serial divider, and then the result is posted.
// in_tready is low from the last word until the result is posted; a posted
// result waits in the output register while the next set loads.
// rst_n is synchronous; stored samples are not cleared.
module iqr_outlier_trimmed_mean #(
  parameter int MAX_SAMPLES = iqrtm_pkg::MAX_SAMPLES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] sample
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] mean, [38:32] kept_count, [39] zero
  output logic [0:0]  out_tuser,  // [0] overflow
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int CW  = $clog2(MAX_SAMPLES + 1);
  localparam int PW  = $clog2(MAX_SAMPLES);
  localparam int SW  = iqrtm_pkg::SAMPLE_W + CW;
  localparam int DVW = iqrtm_pkg::SAMPLE_W;
  localparam int HW  = iqrtm_pkg::HI_W;
  localparam int WW  = iqrtm_pkg::WIDEN_W;
  localparam int MW  = iqrtm_pkg::PROD_W;
  localparam logic [CW-1:0] MAX_C = CW'(MAX_SAMPLES);

  typedef enum logic [9:0] {
    S_LOAD  = 10'b0000000001,
    S_COPY  = 10'b0000000010,
    S_COUNT = 10'b0000000100,
    S_MARK  = 10'b0000001000,
    S_DRAIN = 10'b0000010000,
    S_MUL   = 10'b0000100000,
    S_BOUND = 10'b0001000000,
    S_SUM   = 10'b0010000000,
    S_DIV   = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_t;

  state_t                         state_r, state_nxt;
  logic [CW-1:0]                  cnt_r;
  logic                           dropped_r;
  logic [PW-1:0]                  pc_r;
  logic [iqrtm_pkg::FACTOR_W-1:0] factor_r;
  logic [DVW-1:0]                 q1_r, q3_r;
  logic [MW-1:0]                  prod_r;
  logic [DVW-1:0]                 lo_r;
  logic [HW-1:0]                  hi_r;
  logic [SW-1:0]                  sum_r;
  logic [CW-1:0]                  kept_r;
  logic                           out_valid_r;
  logic [DVW-1:0]                 out_mean_r;
  logic [iqrtm_pkg::KEPT_W-1:0]   out_kept_r;
  logic                           out_ovf_r;

  logic                           in_acc;
  logic                           pass_end;
  logic                           out_free;
  logic [CW-1:0]                  k_lo, k_hi;
  logic [CW+1:0]                  cnt3;
  logic [WW-1:0]                  widen;
  logic                           head_in;
  logic                           div_done;
  logic [SW-1:0]                  quot;
  iqrtm_pkg::cell_ctl_t           ctl;
  iqrtm_pkg::tok_t                head;

  logic [DVW-1:0]                 val_w [MAX_SAMPLES];
  iqrtm_pkg::tok_t                tok_w [MAX_SAMPLES];

  // configuration
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == iqrtm_pkg::REG_FACTOR) ? {16'b0, factor_r} : 32'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      factor_r <= iqrtm_pkg::FACTOR_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                 && (cfg_paddr[2] == iqrtm_pkg::REG_FACTOR)) begin
      factor_r <= cfg_pwdata[15:0];
    end
  end

  // quartile ranks, a rank of zero raised to one
  assign cnt3 = {2'b0, cnt_r} + {1'b0, cnt_r, 1'b0};
  assign k_lo = (cnt_r[CW-1:2] == '0) ? CW'(1) : {2'b0, cnt_r[CW-1:2]};
  assign k_hi = (cnt3[CW+1:2] == '0) ? CW'(1) : cnt3[CW-1+2:2];

  assign in_tready = state_r == S_LOAD;
  assign in_acc    = in_tvalid && in_tready;
  assign pass_end  = pc_r == PW'(MAX_SAMPLES - 1);
  assign out_free  = !out_valid_r || out_tready;

  always_comb begin
    ctl        = '0;
    ctl.shift  = in_acc && (cnt_r != MAX_C);
    ctl.copy   = state_r == S_COPY;
    ctl.count  = state_r == S_COUNT;
    ctl.mark   = state_r == S_MARK;
    ctl.rotate = (state_r == S_DRAIN) || (state_r == S_SUM);
  end

  // cell chain; tokens rotate as a ring through the last cell
  for (genvar i = 0; i < MAX_SAMPLES; i++) begin : g_cell
    iqrtm_cell #(
      .MAX_SAMPLES(MAX_SAMPLES),
      .IDX        (i)
    ) u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .cnt   (cnt_r),
      .k_lo  (k_lo),
      .k_hi  (k_hi),
      .val_in((i == 0) ? in_tdata : val_w[(i == 0) ? 0 : i - 1]),
      .tok_in(tok_w[(i == 0) ? MAX_SAMPLES - 1 : i - 1]),
      .val_o (val_w[i]),
      .tok_o (tok_w[i])
    );
  end

  assign head    = tok_w[MAX_SAMPLES - 1];
  assign widen   = prod_r[MW-1:8];
  assign head_in = head.vld && (head.val >= lo_r) && ({{(HW - DVW){1'b0}}, head.val} <= hi_r);

  // start once the sum is complete; held off while the done pulse is up
  iqrtm_div #(
    .NW(SW),
    .DW(CW)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   ((state_r == S_DIV) && !div_done),
    .dividend(sum_r),
    .divisor (kept_r),
    .done    (div_done),
    .quot    (quot)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_LOAD:  if (in_acc && in_tlast) state_nxt = S_COPY;
      S_COPY:  state_nxt = S_COUNT;
      S_COUNT: if (pass_end) state_nxt = S_MARK;
      S_MARK:  state_nxt = S_DRAIN;
      S_DRAIN: if (pass_end) state_nxt = S_MUL;
      S_MUL:   state_nxt = S_BOUND;
      S_BOUND: state_nxt = S_SUM;
      S_SUM:   if (pass_end) state_nxt = S_DIV;
      S_DIV:   if (div_done) state_nxt = S_OUT;
      S_OUT:   if (out_free) state_nxt = S_LOAD;
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      cnt_r       <= '0;
      dropped_r   <= 1'b0;
      pc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ctl.count || ctl.rotate) begin
        pc_r <= pass_end ? '0 : pc_r + PW'(1);
      end
      if (in_acc) begin
        if (cnt_r != MAX_C) begin
          cnt_r <= cnt_r + CW'(1);
        end else begin
          dropped_r <= 1'b1;
        end
      end
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
        cnt_r       <= '0;
        dropped_r   <= 1'b0;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (state_r == S_DRAIN) begin
      if (head.hlo) q1_r <= head.val;
      if (head.hhi) q3_r <= head.val;
    end
    if (state_r == S_MUL) begin
      prod_r <= {{iqrtm_pkg::FACTOR_W{1'b0}}, q3_r - q1_r}
                * {{DVW{1'b0}}, factor_r};
    end
    if (state_r == S_BOUND) begin
      lo_r  <= ({{(WW - DVW){1'b0}}, q1_r} >= widen) ? q1_r - widen[DVW-1:0] : '0;
      hi_r  <= {{(HW - DVW){1'b0}}, q3_r} + {1'b0, widen};
      sum_r <= '0;
      kept_r <= '0;
    end
    if (state_r == S_SUM && head_in) begin
      sum_r  <= sum_r + {{CW{1'b0}}, head.val};
      kept_r <= kept_r + CW'(1);
    end
    if (state_r == S_OUT && out_free) begin
      out_mean_r <= (kept_r == '0) ? '0 : quot[DVW-1:0];
      out_kept_r <= iqrtm_pkg::KEPT_W'(kept_r);
      out_ovf_r  <= dropped_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_kept_r, out_mean_r};
  assign out_tuser  = out_ovf_r;

  // checks
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= MAX_C) else $error("sample count past capacity");

  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    dropped_r |-> cnt_r == MAX_C) else $error("drop flagged with room left");

  a_kept_nz: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> out_kept_r != '0) else $error("result with no kept samples");

  a_mean_in: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> (out_mean_r >= lo_r)
      && ({{(HW - DVW){1'b0}}, out_mean_r} <= hi_r)) else $error("mean outside bounds");

endmodule

// ----- test/iqr_outlier_trimmed_mean_tb.sv -----
// Self-checking testbench for the IQR outlier trimmed mean block.
`timescale 1ns / 100ps

module iqr_outlier_trimmed_mean_tb;

  localparam int STORE_DEPTH  = iqrtm_pkg::MAX_SAMPLES_DEF;
  // ring passes + divider + post, with margin
  localparam int SETTLE_CYC   = 3 * STORE_DEPTH + 4 + 34 + 7 + 1 + 60;
  localparam int STALL_LIMIT  = 6000;
  localparam int PHASE_WORDS  = 100;
  localparam int NUM_PHASES   = 5;

  typedef struct packed {
    logic [31:0]                  mean;
    logic [iqrtm_pkg::KEPT_W-1:0] kept;
    logic                         ovf;
  } trim_res_t;

  typedef struct {
    logic [31:0] sample;
    logic        last;
    bit          typed;
    trim_res_t   res;
  } dir_row_t;

  typedef enum int {SPREAD_FULL, SPREAD_CLUSTER, SPREAD_TINY, SPREAD_TOP} spread_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;    // [31:0] sample
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;   // [31:0] mean, [38:32] kept_count, [39] zero
  logic [0:0]  out_tuser;   // [0] overflow
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  iqr_outlier_trimmed_mean u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // predictor state
  logic [31:0]                    set_store [STORE_DEPTH];
  int                             set_fill = 0;
  logic                           set_dropped = 1'b0;
  logic [iqrtm_pkg::FACTOR_W-1:0] factor_q88;
  trim_res_t                      expected_trims [$];

  // typed expectation that rides along with the word being driven
  bit                pin_typed;
  trim_res_t         pin_res;

  bit                calm;
  int                err_cnt = 0;
  int                words_in = 0;
  int                sets_in = 0;
  int                trims_seen = 0;
  int                ovf_seen = 0;
  int                stall_cycles = 0;
  dir_row_t          dir_rows [$];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    err_cnt++;
  endtask

  function automatic logic [31:0] kth_smallest(input int m, input int k);
    int below;
    int at_or_below;
    for (int i = 0; i < m; i++) begin
      below = 0;
      at_or_below = 0;
      for (int j = 0; j < m; j++) begin
        if (set_store[j] < set_store[i]) below++;
        if (set_store[j] <= set_store[i]) at_or_below++;
      end
      if (below < k && k <= at_or_below) return set_store[i];
    end
    return 32'd0;
  endfunction

  function automatic trim_res_t predict_trim();
    trim_res_t   r;
    int          k_lo;
    int          k_hi;
    logic [63:0] q1, q3, widen, lo, hi, sum, v, kept;
    k_lo = set_fill / 4;
    k_hi = (3 * set_fill) / 4;
    if (k_lo == 0) k_lo = 1;
    if (k_hi == 0) k_hi = 1;
    q1 = {32'd0, kth_smallest(set_fill, k_lo)};
    q3 = {32'd0, kth_smallest(set_fill, k_hi)};
    widen = (q3 >= q1) ? (((q3 - q1) * {48'd0, factor_q88}) >> 8) : 64'd0;
    lo = (q1 >= widen) ? q1 - widen : 64'd0;
    hi = q3 + widen;
    sum = 64'd0;
    kept = 64'd0;
    for (int i = 0; i < set_fill; i++) begin
      v = {32'd0, set_store[i]};
      if (lo <= v && v <= hi) begin
        sum += v;
        kept++;
      end
    end
    r.mean = (kept != 0) ? 32'(sum / kept) : 32'd0;
    r.kept = kept[iqrtm_pkg::KEPT_W-1:0];
    r.ovf  = set_dropped;
    return r;
  endfunction

  // input side: accepted words fill the predictor store; words past its depth flag a drop
  always @(posedge clk) begin : in_mon
    trim_res_t r;
    if (rst_n && in_tvalid && in_tready) begin
      words_in++;
      if (set_fill < STORE_DEPTH) begin
        set_store[set_fill] = in_tdata;
        set_fill++;
      end else begin
        set_dropped = 1'b1;
      end
      if (in_tlast) begin
        r = predict_trim();
        if (pin_typed) r = pin_res;
        expected_trims = {expected_trims, r};
        set_fill = 0;
        set_dropped = 1'b0;
        sets_in++;
      end
    end
  end

  // result side
  always @(posedge clk) begin : out_mon
    trim_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      trims_seen++;
      if (out_tuser[0]) ovf_seen++;
      if (expected_trims.size() == 0) begin
        flag_mismatch("result with nothing expected", {23'd0, out_tuser, out_tdata}, 64'd0);
      end else begin
        want = expected_trims.pop_front();
        if (out_tdata[31:0] !== want.mean)
          flag_mismatch("mean", 64'(out_tdata[31:0]), 64'(want.mean));
        if (out_tdata[38:32] !== want.kept)
          flag_mismatch("kept_count", 64'(out_tdata[38:32]), 64'(want.kept));
        if (out_tuser[0] !== want.ovf)
          flag_mismatch("overflow", 64'(out_tuser[0]), 64'(want.ovf));
        if (out_tdata[39] !== 1'b0)
          flag_mismatch("tdata pad", 64'(out_tdata[39]), 64'd0);
      end
    end
  end

  always @(negedge clk) begin
    out_tready <= calm ? 1'b1 : ($urandom_range(99) >= 18);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles, %0d results pending",
                 stall_cycles, expected_trims.size());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic push_word(input logic [31:0] sample, input logic last,
                           input bit typed, input trim_res_t res);
    while (!calm && $urandom_range(99) < 18) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = sample;
    in_tlast  = last;
    pin_typed = typed;
    pin_res   = res;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic cfg_write_factor(input logic [iqrtm_pkg::FACTOR_W-1:0] value);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = {iqrtm_pkg::REG_FACTOR, 2'b00};
    // upper bits are junk on purpose; only the low 16 count
    cfg_pwdata  = {16'($urandom()), value};
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    factor_q88 = value;
    @(negedge clk);
    cfg_pwrite  = 1'b0;
    cfg_penable = 1'b0;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata[iqrtm_pkg::FACTOR_W-1:0] !== factor_q88)
      flag_mismatch("factor readback", 64'(cfg_prdata[iqrtm_pkg::FACTOR_W-1:0]),
                    64'(factor_q88));
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
  endtask

  task automatic drain_results();
    in_tvalid = 1'b0;
    while (expected_trims.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic add_row(input logic [31:0] sample, input logic last, input bit typed,
                         input logic [31:0] mean,
                         input logic [iqrtm_pkg::KEPT_W-1:0] kept);
    dir_row_t row;
    row.sample   = sample;
    row.last     = last;
    row.typed    = typed;
    row.res.mean = mean;
    row.res.kept = kept;
    row.res.ovf  = 1'b0;
    dir_rows = {dir_rows, row};
  endtask

  function automatic logic [31:0] pick_sample(input spread_t spread, input logic [31:0] base);
    case (spread)
      SPREAD_FULL:    return $urandom();
      SPREAD_CLUSTER: return ($urandom_range(99) < 10) ? $urandom() : base + $urandom_range(255);
      SPREAD_TINY:    return $urandom_range(15);
      default:        return ($urandom_range(99) < 15) ? $urandom_range(1000)
                                                      : (32'hFFFFFF00 | $urandom_range(255));
    endcase
  endfunction

  function automatic int pick_set_len();
    int r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(12, 1);
    if (r < 80) return $urandom_range(40, 13);
    if (r < 86) return STORE_DEPTH;
    if (r < 92) return $urandom_range(STORE_DEPTH + 6, STORE_DEPTH + 1);
    return $urandom_range(3, 1);
  endfunction

  function automatic logic [iqrtm_pkg::FACTOR_W-1:0] phase_factor(input int phase);
    case (phase)
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'd256;
      3:       return 16'($urandom());
      default: return iqrtm_pkg::FACTOR_RST;
    endcase
  endfunction

  task automatic play_set(input int len);
    spread_t     spread;
    logic [31:0] base;
    trim_res_t   none;
    none   = '0;
    spread = spread_t'($urandom_range(3));
    base   = $urandom_range(32'hFFFF0000);
    for (int i = 0; i < len; i++)
      push_word(pick_sample(spread, base), i == len - 1, 1'b0, none);
  endtask

  initial begin : stim
    int        phase_words;
    int        len;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tlast    = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    pin_typed   = 1'b0;
    pin_res     = '0;
    calm        = 1'b0;
    factor_q88  = iqrtm_pkg::FACTOR_RST;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed sets, reset factor of 1.5
    add_row(32'd0,         1'b1, 1'b1, 32'd0,         7'd1);
    add_row(32'hFFFFFFFF,  1'b1, 1'b1, 32'hFFFFFFFF,  7'd1);
    for (int i = 0; i < 3; i++) add_row(32'd5, 1'b0, 1'b0, 32'd0, 7'd0);
    add_row(32'd5,         1'b1, 1'b1, 32'd5,         7'd4);
    // one far outlier among equal values, zero spread drops it
    for (int i = 0; i < 3; i++) add_row(32'd10, 1'b0, 1'b0, 32'd0, 7'd0);
    add_row(32'd1000,      1'b0, 1'b0, 32'd0,         7'd0);
    for (int i = 0; i < 3; i++) add_row(32'd10, 1'b0, 1'b0, 32'd0, 7'd0);
    add_row(32'd10,        1'b1, 1'b1, 32'd10,        7'd7);
    // lower bound clamps at zero
    add_row(32'd1,         1'b0, 1'b0, 32'd0,         7'd0);
    add_row(32'd1000000,   1'b0, 1'b0, 32'd0,         7'd0);
    add_row(32'd2,         1'b0, 1'b0, 32'd0,         7'd0);
    add_row(32'd3000000,   1'b1, 1'b0, 32'd0,         7'd0);
    // upper bound past 32 bits
    add_row(32'd0,         1'b0, 1'b0, 32'd0,         7'd0);
    for (int i = 0; i < 2; i++) add_row(32'hFFFFFFFF, 1'b0, 1'b0, 32'd0, 7'd0);
    add_row(32'hFFFFFFFF,  1'b1, 1'b0, 32'd0,         7'd0);
    foreach (dir_rows[i])
      push_word(dir_rows[i].sample, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].res);
    drain_results();

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      cfg_write_factor(phase_factor(phase));
      calm = (phase == 2);
      phase_words = 0;
      // store full, including a dropped word that carries last
      if (phase == 0) begin
        play_set(STORE_DEPTH + 2);
        phase_words += STORE_DEPTH + 2;
      end
      while (phase_words < PHASE_WORDS) begin
        len = pick_set_len();
        play_set(len);
        phase_words += len;
      end
      drain_results();
    end
    calm = 1'b0;

    $display("run: %0d words in %0d sets, %0d results, %0d over capacity",
             words_in, sets_in, trims_seen, ovf_seen);
    $display("run: factors 1.5, 0, max, 1.0, random, 1.5; %0d mismatches", err_cnt);
    if (err_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
